### src/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types, codes and hash helpers for the chained hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int DEF_BUCKETS = 1024;
  localparam int DEF_ENTRIES = 1024;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_O_W = 11;
  localparam int BB_W    = 4;
  localparam logic [BB_W-1:0] BB_RESET = 4'd10;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_PUT    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_PRESENT = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  localparam logic ADDR_BUCKET_BITS = 1'b0;

  typedef struct packed {
    logic    accept;
    logic    hash1;
    logic    hash2;
    logic    rd_head;
    logic    take_head;
    logic    rd_ent;
    logic    step;
    logic    hit;
    logic    wr_val;
    logic    unlink;
    logic    rd_free;
    logic    insert;
    logic    clr_start;
    logic    clr_step;
    logic    load_out;
    status_t out_status;
  } chm_ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic cur_null;
    logic match;
    logic full;
    logic clr_last;
    logic out_busy;
  } chm_stat_t;

  function automatic logic [KEY_W-1:0] mix_a(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = k + ~(k << 9);
    return h ^ (h >> 14);
  endfunction

  function automatic logic [KEY_W-1:0] mix_b(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = k + (k << 4);
    return h ^ (h >> 10);
  endfunction

endpackage

### src/chm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ifs
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface chm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key;
  logic [31:0] new_value;
  modport source (output valid, cmd, key, new_value, input ready);
  modport sink (input valid, cmd, key, new_value, output ready);
endinterface

interface chm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] old_value;
  logic [1:0]  status;
  logic [10:0] entry_count;
  modport source (output valid, old_value, status, entry_count, input ready);
  modport sink (input valid, old_value, status, entry_count, output ready);
endinterface

### src/chm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ctrl
// Sequencer: hash, head read, chain walk, update, clear sweep, result.
// ----------------------------------------------------------------------------
module chm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  chm_pkg::chm_stat_t stat,
  output chm_pkg::chm_ctrl_t ctrl
);
  import chm_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_H1, S_H2, S_HEAD, S_HEADW, S_CHK, S_CMP, S_INS, S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  logic    report_r, report_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ctrl       = '0;
    ctrl.out_status = status_r;
    state_nxt  = state_r;
    status_nxt = status_r;
    report_nxt = report_r;
    unique case (state_r)
      S_CLR: begin
        ctrl.clr_step = 1'b1;
        if (stat.clr_last) begin
          if (report_r) begin
            state_nxt  = S_DONE;
            status_nxt = ST_PRESENT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          state_nxt   = S_H1;
        end
      end
      S_H1: begin
        if (stat.cmd == CMD_CLEAR) begin
          ctrl.clr_start = 1'b1;
          report_nxt     = 1'b1;
          state_nxt      = S_CLR;
        end else begin
          ctrl.hash1 = 1'b1;
          state_nxt  = S_H2;
        end
      end
      S_H2: begin
        ctrl.hash2 = 1'b1;
        state_nxt  = S_HEAD;
      end
      S_HEAD: begin
        ctrl.rd_head = 1'b1;
        state_nxt    = S_HEADW;
      end
      S_HEADW: begin
        ctrl.take_head = 1'b1;
        state_nxt      = S_CHK;
      end
      S_CHK: begin
        if (!stat.cur_null) begin
          ctrl.rd_ent = 1'b1;
          state_nxt   = S_CMP;
        end else if (stat.cmd == CMD_PUT && !stat.full) begin
          ctrl.rd_free = 1'b1;
          state_nxt    = S_INS;
        end else begin
          status_nxt = (stat.cmd == CMD_PUT) ? ST_FULL : ST_ABSENT;
          state_nxt  = S_DONE;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          ctrl.hit    = 1'b1;
          ctrl.wr_val = (stat.cmd == CMD_PUT);
          ctrl.unlink = (stat.cmd == CMD_REMOVE);
          status_nxt  = ST_PRESENT;
          state_nxt   = S_DONE;
        end else begin
          ctrl.step = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_INS: begin
        ctrl.insert = 1'b1;
        status_nxt  = ST_ABSENT;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctrl.load_out = 1'b1;
          report_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      status_r <= ST_PRESENT;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      report_r <= report_nxt;
    end
  end

endmodule

### src/chm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_dpath
// Bucket heads, entry pool, free stack, hash unit and result register.
// ----------------------------------------------------------------------------
module chm_dpath #(
  parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
  parameter int ENTRIES = chm_pkg::DEF_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  chm_pkg::chm_ctrl_t        ctrl,
  output chm_pkg::chm_stat_t        stat,
  input  logic [chm_pkg::BB_W-1:0]  bucket_bits,
  input  logic [1:0]                in_cmd,
  input  logic [chm_pkg::KEY_W-1:0] in_key,
  input  logic [chm_pkg::VAL_W-1:0] in_new_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [chm_pkg::VAL_W-1:0] out_old_value,
  output logic [1:0]                out_status,
  output logic [chm_pkg::CNT_O_W-1:0] out_entry_count,
  output logic [$clog2(ENTRIES+1)-1:0] count
);
  import chm_pkg::*;

  localparam int MAXB  = $clog2(BUCKETS + 1) - 1;
  localparam int BW    = MAXB;
  localparam int NB    = 1 << MAXB;
  localparam int AW    = $clog2(ENTRIES);
  localparam int LW    = AW + 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  logic [LW-1:0]    heads_mem [NB];
  logic [KEY_W-1:0] keys_mem  [ENTRIES];
  logic [VAL_W-1:0] vals_mem  [ENTRIES];
  logic [LW-1:0]    links_mem [ENTRIES];
  logic [AW-1:0]    free_mem  [ENTRIES];

  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r, hash_r;
  logic [VAL_W-1:0] val_r, old_r;
  logic [BW-1:0]    bkt_r, clr_r;
  logic [LW-1:0]    cur_r, prev_r, head_r;
  logic [CW-1:0]    count_r, hwm_r;
  logic [LW-1:0]    head_q, link_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [AW-1:0]    free_q;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_old_r;
  status_t          out_status_r;
  logic [CW-1:0]    out_count_r;

  logic [4:0]       bb_c;
  logic [BW-1:0]    mask;
  logic [AW-1:0]    cur_a, prev_a, new_e;
  logic [CW-1:0]    count_dec;
  logic [KEY_W-1:0] hash2_c;

  always_comb begin
    if (bucket_bits == '0) begin
      bb_c = 5'd1;
    end else if ({1'b0, bucket_bits} > 5'(MAXB)) begin
      bb_c = 5'(MAXB);
    end else begin
      bb_c = {1'b0, bucket_bits};
    end
  end

  assign mask      = ~({BW{1'b1}} << bb_c);
  assign cur_a     = cur_r[AW-1:0];
  assign prev_a    = prev_r[AW-1:0];
  assign count_dec = count_r - CW'(1);
  assign new_e     = (count_r < hwm_r) ? free_q : count_r[AW-1:0];
  assign hash2_c   = mix_b(hash_r);

  assign stat.cmd      = cmd_r;
  assign stat.cur_null = (cur_r >= NULL_LINK);
  assign stat.match    = (key_q == key_r);
  assign stat.full     = (count_r >= CW'(ENTRIES));
  assign stat.clr_last = (clr_r == BW'(NB - 1));
  assign stat.out_busy = out_valid_r && !out_ready;

  // bucket heads
  always_ff @(posedge clk) begin
    if (ctrl.clr_step) begin
      heads_mem[clr_r] <= NULL_LINK;
    end else if (ctrl.unlink && prev_r >= NULL_LINK) begin
      heads_mem[bkt_r] <= link_q;
    end else if (ctrl.insert) begin
      heads_mem[bkt_r] <= LW'(new_e);
    end
    if (ctrl.rd_head) begin
      head_q <= heads_mem[bkt_r];
    end
  end

  // entry pool
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      keys_mem[new_e] <= key_r;
    end
    if (ctrl.rd_ent) begin
      key_q <= keys_mem[cur_a];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      vals_mem[new_e] <= val_r;
    end else if (ctrl.wr_val) begin
      vals_mem[cur_a] <= val_r;
    end
    if (ctrl.rd_ent) begin
      val_q <= vals_mem[cur_a];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      links_mem[new_e] <= head_r;
    end else if (ctrl.unlink && prev_r < NULL_LINK) begin
      links_mem[prev_a] <= link_q;
    end
    if (ctrl.rd_ent) begin
      link_q <= links_mem[cur_a];
    end
  end

  // free stack
  always_ff @(posedge clk) begin
    if (ctrl.unlink) begin
      free_mem[count_dec[AW-1:0]] <= cur_a;
    end
    if (ctrl.rd_free) begin
      free_q <= free_mem[count_r[AW-1:0]];
    end
  end

  // item payload and walk pointers
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_r <= cmd_t'(in_cmd);
      key_r <= in_key;
      val_r <= in_new_value;
    end
    if (ctrl.accept) begin
      old_r <= '0;
    end else if (ctrl.hit) begin
      old_r <= val_q;
    end
    if (ctrl.hash1) begin
      hash_r <= mix_a(key_r);
    end
    if (ctrl.hash2) begin
      bkt_r <= hash2_c[BW-1:0] & mask;
    end
    if (ctrl.take_head) begin
      cur_r  <= head_q;
      head_r <= head_q;
      prev_r <= NULL_LINK;
    end else if (ctrl.step) begin
      prev_r <= cur_r;
      cur_r  <= link_q;
    end
  end

  // counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      hwm_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.clr_start) begin
        count_r <= '0;
        hwm_r   <= '0;
        clr_r   <= '0;
      end else begin
        if (ctrl.clr_step) begin
          clr_r <= clr_r + BW'(1);
        end
        if (ctrl.unlink) begin
          count_r <= count_dec;
        end else if (ctrl.insert) begin
          count_r <= count_r + CW'(1);
          if (count_r >= hwm_r) begin
            hwm_r <= count_r + CW'(1);
          end
        end
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_old_r    <= old_r;
      out_status_r <= ctrl.out_status;
      out_count_r  <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_old_value   = out_old_r;
  assign out_status      = out_status_r;
  assign out_entry_count = CNT_O_W'(out_count_r);
  assign count           = count_r;

endmodule

### src/chained_hash_map_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// 32-bit key to 32-bit value map with chained buckets and a free stack.
// ----------------------------------------------------------------------------
// One command at a time. Get, put and remove hash the key (mix_a, then mix_b
// and the bucket mask), read the bucket head and walk the chain with one
// memory read and one compare per entry; a hit ends the walk, and a put that
// misses adds an insert. Clear resets the counters, then sweeps all
// 2^floor(log2 BUCKETS) bucket heads one per cycle, and the same sweep runs
// after reset before the first item is taken. A result still waiting on the
// output holds the next result, and with it the input, until it is taken.
// Configuration should be written only while no command is in flight.
module chained_hash_map_engine #(
  parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
  parameter int ENTRIES = chm_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  chm_req_if.sink     in_ch,
  chm_rsp_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import chm_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  chm_ctrl_t        ctrl;
  chm_stat_t        stat;
  logic [BB_W-1:0]  bb_r;
  logic [CW-1:0]    count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_BUCKET_BITS) ? {28'd0, bb_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r <= BB_RESET;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_BUCKET_BITS) begin
      bb_r <= pwdata[BB_W-1:0];
    end
  end

  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  chm_dpath #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .bucket_bits     (bb_r),
    .in_cmd          (in_ch.cmd),
    .in_key          (in_ch.key),
    .in_new_value    (in_ch.new_value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_old_value   (out_ch.old_value),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count),
    .count           (count)
  );

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(ENTRIES))
    else $error("stored count beyond pool size");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status != ST_UNUSED)
    else $error("undefined status code");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken while busy");
`endif

endmodule

### tb/sv/tb_chained_hash_map_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_map_engine
// Self-checking bench for the chained hash map engine. A scoreboard class
// keeps its own copy of the map (bucket heads, entry pool, free stack) and
// predicts every response; requests and responses are throttled at random,
// the pool is loaded with over two hundred entries and the bucket mask is swept
// across and beyond its legal range.
// ----------------------------------------------------------------------------
module tb_chained_hash_map_engine;
  import chm_pkg::*;

  localparam int NB = DEF_BUCKETS;
  localparam int NE = DEF_ENTRIES;

  typedef struct {
    logic [31:0] old_value;
    status_t     status;
    logic [10:0] entry_count;
  } map_rsp_t;

  class map_scoreboard;
    logic [10:0] heads[NB];
    logic [31:0] keys[NE];
    logic [31:0] vals[NE];
    logic [10:0] links[NE];
    logic [9:0]  free_idx[NE];
    logic [10:0] count;
    logic [3:0]  bucket_bits;
    map_rsp_t    pending[$];
    int          errors;
    int          n_rsp;
    int          n_full;
    int          n_hit;

    function new();
      errors = 0;
      n_rsp = 0;
      n_full = 0;
      n_hit = 0;
      bucket_bits = BB_RESET;
      for (int i = 0; i < NE; i++) begin
        keys[i] = '0;
        vals[i] = '0;
        links[i] = '0;
      end
      empty_map();
    endfunction

    function void empty_map();
      for (int i = 0; i < NB; i++) heads[i] = 11'(NE);
      for (int i = 0; i < NE; i++) free_idx[i] = 10'(i);
      count = '0;
    endfunction

    function logic [9:0] bucket_index(logic [31:0] k);
      logic [31:0] h;
      int b;
      h = k;
      h = h + ~(h << 9);
      h = h ^ (h >> 14);
      h = h + (h << 4);
      h = h ^ (h >> 10);
      b = bucket_bits;
      if (b < 1) b = 1;
      if (b > $clog2(NB)) b = $clog2(NB);
      return 10'(h & ((32'd1 << b) - 32'd1));
    endfunction

    function void note_request(cmd_t c, logic [31:0] k, logic [31:0] v);
      map_rsp_t r;
      logic [9:0] b;
      logic [10:0] cur, prev, e;
      int steps;
      bit found;
      r.old_value = '0;
      r.status = ST_ABSENT;
      found = 0;
      if (c == CMD_CLEAR) begin
        empty_map();
        r.status = ST_PRESENT;
      end else begin
        b = bucket_index(k);
        cur = heads[b];
        prev = 11'(NE);
        steps = 0;
        while (cur < NE && steps < NE) begin
          if (keys[cur] == k) begin
            found = 1;
            break;
          end
          prev = cur;
          cur = links[cur];
          steps++;
        end
        if (found) begin
          r.old_value = vals[cur];
          r.status = ST_PRESENT;
          n_hit++;
          if (c == CMD_PUT) begin
            vals[cur] = v;
          end else if (c == CMD_REMOVE) begin
            if (prev < NE) links[prev] = links[cur];
            else heads[b] = links[cur];
            keys[cur] = '0;
            vals[cur] = '0;
            links[cur] = 11'(NE);
            if (count > 0) begin
              count--;
              free_idx[count] = cur[9:0];
            end
          end
        end else if (c == CMD_PUT) begin
          if (count >= NE) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            e = {1'b0, free_idx[count]};
            count++;
            keys[e] = k;
            vals[e] = v;
            links[e] = heads[b];
            heads[b] = e;
          end
        end
      end
      r.entry_count = count;
      pending.push_back(r);
    endfunction

    function void check_response(logic [31:0] ov, logic [1:0] st, logic [10:0] cnt);
      map_rsp_t r;
      n_rsp++;
      if (pending.size() == 0) begin
        $error("unexpected response: old_value %h status %0d entry_count %0d", ov, st, cnt);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (ov !== r.old_value) begin
        $error("old_value: expected %h, got %h", r.old_value, ov);
        errors++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        errors++;
      end
      if (cnt !== r.entry_count) begin
        $error("entry_count: expected %0d, got %0d", r.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  chm_req_if req_ch ();
  chm_rsp_if rsp_ch ();

  map_scoreboard sb;
  bit          no_idle;
  int          hold_request;
  logic [31:0] key_pool[48];

  chained_hash_map_engine i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(cmd_t c, logic [31:0] k, logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.key <= k;
    req_ch.new_value <= v;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(c, k, v);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_bucket_bits(logic [3:0] bb);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'd4 * ADDR_BUCKET_BITS;
    pwdata <= {28'd0, bb};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.bucket_bits = bb;
  endtask

  task automatic random_phase(int n);
    int r;
    cmd_t c;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 42) c = CMD_PUT;
      else if (r < 68) c = CMD_GET;
      else if (r < 97) c = CMD_REMOVE;
      else c = CMD_CLEAR;
      if ($urandom_range(0, 99) < 8) k = $urandom();
      else k = key_pool[$urandom_range(0, 47)];
      send_item(c, k, $urandom());
    end
  endtask

  // response side: random stalls plus one long hold on request
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && !no_idle) begin
        if ($urandom_range(0, 99) < 25) stall = $urandom_range(1, 3);
        else if ($urandom_range(0, 99) < 3) stall = $urandom_range(15, 50);
      end
      rsp_ch.ready <= (stall == 0);
      if (stall > 0) stall--;
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.old_value, rsp_ch.status, rsp_ch.entry_count);
    end
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [31:0] fill_key;
    sb = new();
    no_idle = 0;
    hold_request = 0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_GET;
    req_ch.key = '0;
    req_ch.new_value = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: two buckets so chains collide
    write_bucket_bits(4'd0);
    send_item(CMD_GET, 32'h0, 32'h0);
    send_item(CMD_PUT, 32'h0, 32'hffffffff);
    send_item(CMD_PUT, 32'hffffffff, 32'h0);
    send_item(CMD_PUT, 32'h0, 32'h12345678);
    send_item(CMD_GET, 32'hffffffff, 32'h0);
    for (int i = 1; i <= 6; i++) send_item(CMD_PUT, i, 32'h100 + i);
    send_item(CMD_REMOVE, 32'd3, 32'h0);
    send_item(CMD_REMOVE, 32'd6, 32'h0);
    send_item(CMD_REMOVE, 32'h0, 32'h0);
    send_item(CMD_GET, 32'd3, 32'h0);
    send_item(CMD_REMOVE, 32'd3, 32'h0);
    send_item(CMD_GET, 32'd1, 32'h0);
    send_item(CMD_CLEAR, 32'hdeadbeef, 32'hcafef00d);
    send_item(CMD_GET, 32'd1, 32'h0);
    wait_drained();

    // load over two hundred entries, out-of-range mask
    write_bucket_bits(4'd15);
    for (int i = 0; i < 200; i++) begin
      fill_key = i * 32'h9e3779b9 ^ 32'h5a5a0000;
      send_item(CMD_PUT, fill_key, $urandom());
    end
    send_item(CMD_PUT, 32'h5a5a0000, 32'haaaa5555);
    send_item(CMD_PUT, 32'h00c0ffee, 32'h1);
    send_item(CMD_REMOVE, 32'h9e3779b9 ^ 32'h5a5a0000, 32'h0);
    send_item(CMD_PUT, 32'h00c0ffee, 32'h2);
    send_item(CMD_PUT, 32'h00c0ffe0, 32'h3);
    send_item(CMD_CLEAR, 32'h0, 32'h0);
    wait_drained();

    write_bucket_bits(4'd1);
    random_phase(60);
    wait_drained();
    write_bucket_bits(4'd4);
    hold_request = 300;
    random_phase(60);
    wait_drained();
    write_bucket_bits(4'd10);
    no_idle = 1;
    random_phase(60);
    no_idle = 0;
    wait_drained();
    write_bucket_bits(4'd2);
    random_phase(60);
    wait_drained();
    write_bucket_bits(4'd0);
    random_phase(50);
    wait_drained();
    write_bucket_bits(4'd15);
    random_phase(50);
    wait_drained();
    write_bucket_bits(4'd7);
    random_phase(40);
    wait_drained();

    $display("covered: %0d responses, %0d key hits, %0d pool-full puts", sb.n_rsp, sb.n_hit,
             sb.n_full);
    $display("bucket masks swept from 0 to 15 with a loaded pool, long output stalls and clears");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
src/chm_pkg.sv
src/chm_ifs.sv
src/chm_ctrl.sv
src/chm_dpath.sv
src/chained_hash_map_engine.sv
tb/sv/tb_chained_hash_map_engine.sv
